>>> hdl/block_cache_tag_lru_assert.svh
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine: assertion macros
// Shared forms for the concurrent checks on the engine's ports.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CACHE_TAG_LRU_ASSERT_SVH
`define BLOCK_CACHE_TAG_LRU_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCTL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block_cache_tag_lru: check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define BCTL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block_cache_tag_lru: check failed one cycle later");

`endif

>>> hdl/bctl_pkg.sv
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine: package
// Field widths, item layouts, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package bctl_pkg;

   localparam int FILE_ID_W     = 3;
   localparam int FILE_SIZE_W   = 32;
   localparam int BLOCK_NUM_W   = 23;
   localparam int STATUS_W      = 3;
   localparam int SLOT_W        = 4;
   localparam int BYTE_COUNT_W  = 10;
   localparam int TOTAL_W       = 32;
   localparam int STAMP_W       = 32;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 120;

   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   typedef enum logic {
      OP_LOOKUP,
      OP_FLUSH
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT,
      STATUS_FILLED,
      STATUS_UNMOUNTED,
      STATUS_PAST_END,
      STATUS_NO_SLOT
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_RESOLVE,
      S_COMMIT
   } state_type;

endpackage

>>> hdl/block_cache_tag_lru.sv
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine
// Fully associative tag store with least-recently-stamped replacement.
// ----------------------------------------------------------------------------
// The req channel carries one lookup or flush item; the rsp channel returns
// exactly one result item for each request. A lookup walks all SLOTS tag
// entries through the tag RAM, one read per cycle, looking for a matching
// (file, block) pair, a free slot and the oldest stamp at the same time.
// A hit restamps the entry; a miss on a mounted file whose block starts
// inside the file fills the first free slot or else the oldest one.
// A lookup passes through the scan, drain, resolve and commit states in order;
// a flush goes straight from idle to commit. One item is in work at a time;
// req_tready is high only while the engine is idle. The result sits in an
// output register, so the engine finishes an item while an earlier result
// waits; it then holds until the receiver takes that result. Reset clears
// the valid bits, the use clock and the counters; no clearing pass over the
// RAM is needed.
// ----------------------------------------------------------------------------
module block_cache_tag_lru
   import bctl_pkg::*;
#(
   parameter int SLOTS       = 16,
   parameter int BLOCK_BYTES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // file_id[2:0], file_mounted[3], file_size[35:4], block[58:36]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], slot[6:3], byte_count[16:7], hit_total[48:17],
   // miss_total[80:49], fill_total[112:81]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BYTES_W = $clog2(BLOCK_BYTES + 1);
   localparam int START_W = BLOCK_NUM_W + BYTES_W;
   localparam int CMP_W   = (START_W > FILE_SIZE_W) ? START_W : FILE_SIZE_W;
   localparam int ENTRY_W = FILE_ID_W + BLOCK_NUM_W + BYTES_W + STAMP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type state_ff, state_in;

   logic                     op_ff;
   logic [FILE_ID_W-1:0]     file_id_ff;
   logic                     mounted_ff;
   logic [FILE_SIZE_W-1:0]   size_ff;
   logic [BLOCK_NUM_W-1:0]   block_ff;
   logic [START_W-1:0]       start_ff;

   logic [IDX_W-1:0]   rd_idx_ff;
   logic               chk_en_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               hit_found_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [BYTES_W-1:0] hit_bytes_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic               best_found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [STAMP_W-1:0] best_stamp_ff;

   status_type         res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [BYTES_W-1:0] res_bytes_ff, res_bytes_in;

   logic               valid_ff [SLOTS];
   logic [STAMP_W-1:0] use_clock_ff, use_clock_in;
   logic [TOTAL_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0] miss_cnt_ff, miss_cnt_in;
   logic [TOTAL_W-1:0] fill_cnt_ff, fill_cnt_in;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                     req_fire;
   logic                     out_free;
   logic                     commit;
   logic                     ram_rd_en;
   logic                     ram_wr_en;
   logic [ENTRY_W-1:0]       ram_wr_data;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic [FILE_ID_W-1:0]     rd_file;
   logic [BLOCK_NUM_W-1:0]   rd_block;
   logic [BYTES_W-1:0]       rd_bytes;
   logic [STAMP_W-1:0]       rd_stamp;
   logic                     chk_valid;
   logic                     chk_match;
   logic [CMP_W-1:0]         size_ext;
   logic [CMP_W-1:0]         start_ext;
   logic [CMP_W-1:0]         tail_diff;
   logic [BYTES_W-1:0]       tail_bytes;
   logic                     write_entry;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = (state_ff == S_COMMIT) && out_free;

   // Tag RAM entry layout, high to low: file, block, bytes, stamp.
   bctl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(res_idx_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rd_data)
   );

   assign ram_rd_en = (state_ff == S_SCAN);
   assign rd_file   = ram_rd_data[ENTRY_W-1 -: FILE_ID_W];
   assign rd_block  = ram_rd_data[STAMP_W+BYTES_W +: BLOCK_NUM_W];
   assign rd_bytes  = ram_rd_data[STAMP_W +: BYTES_W];
   assign rd_stamp  = ram_rd_data[STAMP_W-1:0];

   assign chk_valid = valid_ff[chk_idx_ff];
   assign chk_match = chk_valid && (rd_file == file_id_ff) && (rd_block == block_ff);

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = (op_type'(req_tuser) == OP_FLUSH) ? S_COMMIT : S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_tuser;
         file_id_ff <= req_tdata[2:0];
         mounted_ff <= req_tdata[3];
         size_ff    <= req_tdata[35:4];
         block_ff   <= req_tdata[58:36];
      end
      start_ff <= START_W'(block_ff) * START_W'(BLOCK_BYTES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_en_ff <= 1'b0;
      end else begin
         chk_en_ff <= (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= rd_idx_ff;
      if (req_fire) begin
         rd_idx_ff     <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         best_stamp_ff <= STAMP_MAX;
      end else begin
         if (state_ff == S_SCAN) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (chk_en_ff) begin
            if (chk_match && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= chk_idx_ff;
               hit_bytes_ff <= rd_bytes;
            end
            if (!chk_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= chk_idx_ff;
            end
            if (chk_valid && (rd_stamp < best_stamp_ff)) begin
               best_found_ff <= 1'b1;
               best_idx_ff   <= chk_idx_ff;
               best_stamp_ff <= rd_stamp;
            end
         end
      end
   end

   always_comb begin
      size_ext   = CMP_W'(size_ff);
      start_ext  = CMP_W'(start_ff);
      tail_diff  = size_ext - start_ext;
      tail_bytes = (tail_diff > CMP_W'(BLOCK_BYTES)) ? BYTES_W'(BLOCK_BYTES)
                                                     : tail_diff[BYTES_W-1:0];
      res_status_in = STATUS_NO_SLOT;
      res_idx_in    = '0;
      res_bytes_in  = '0;
      priority if (hit_found_ff) begin
         res_status_in = STATUS_HIT;
         res_idx_in    = hit_idx_ff;
         res_bytes_in  = hit_bytes_ff;
      end else if (!mounted_ff) begin
         res_status_in = STATUS_UNMOUNTED;
      end else if (start_ext >= size_ext) begin
         res_status_in = STATUS_PAST_END;
      end else if (free_found_ff) begin
         res_status_in = STATUS_FILLED;
         res_idx_in    = free_idx_ff;
         res_bytes_in  = tail_bytes;
      end else if (best_found_ff) begin
         res_status_in = STATUS_FILLED;
         res_idx_in    = best_idx_ff;
         res_bytes_in  = tail_bytes;
      end else begin
         res_status_in = STATUS_NO_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_status_ff <= STATUS_HIT;
         res_idx_ff    <= '0;
         res_bytes_ff  <= '0;
      end else if (state_ff == S_RESOLVE) begin
         res_status_ff <= res_status_in;
         res_idx_ff    <= res_idx_in;
         res_bytes_ff  <= res_bytes_in;
      end
   end

   always_comb begin
      use_clock_in = use_clock_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      fill_cnt_in  = fill_cnt_ff;
      write_entry  = 1'b0;
      if (op_type'(op_ff) == OP_FLUSH) begin
         use_clock_in = '0;
         hit_cnt_in   = '0;
         miss_cnt_in  = '0;
         fill_cnt_in  = '0;
      end else begin
         unique case (res_status_ff)
            STATUS_HIT: begin
               use_clock_in = use_clock_ff + 1'b1;
               hit_cnt_in   = hit_cnt_ff + 1'b1;
               write_entry  = 1'b1;
            end
            STATUS_FILLED: begin
               use_clock_in = use_clock_ff + 1'b1;
               miss_cnt_in  = miss_cnt_ff + 1'b1;
               fill_cnt_in  = fill_cnt_ff + 1'b1;
               write_entry  = 1'b1;
            end
            default: begin
               miss_cnt_in = miss_cnt_ff + 1'b1;
            end
         endcase
      end
   end

   assign ram_wr_en   = commit && write_entry;
   assign ram_wr_data = {file_id_ff, block_ff, res_bytes_ff, use_clock_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         use_clock_ff <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         fill_cnt_ff  <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         use_clock_ff <= use_clock_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         fill_cnt_ff  <= fill_cnt_in;
         if (op_type'(op_ff) == OP_FLUSH) begin
            for (int i = 0; i < SLOTS; i++) begin
               valid_ff[i] <= 1'b0;
            end
         end else if (res_status_ff == STATUS_FILLED) begin
            valid_ff[res_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= {
            (RSP_TDATA_W - 113)'(0),
            fill_cnt_in,
            miss_cnt_in,
            hit_cnt_in,
            BYTE_COUNT_W'(res_bytes_ff),
            SLOT_W'(res_idx_ff),
            res_status_ff
         };
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/bctl_ram.sv
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine: generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bctl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bctl_checker.sv
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine: port checker
// Concurrent checks on the engine's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "block_cache_tag_lru_assert.svh"

module bctl_checker
   import bctl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_is_error;

   assign rsp_status   = rsp_tdata[STATUS_W-1:0];
   assign rsp_is_error = (rsp_status == STATUS_UNMOUNTED) ||
                         (rsp_status == STATUS_PAST_END) ||
                         (rsp_status == STATUS_NO_SLOT);

   `BCTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   `BCTL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      !req_tready)

   `BCTL_ASSERT_SAME(a_error_zero_fields, clock, reset, rsp_tvalid && rsp_is_error,
      rsp_tdata[16:3] == 14'd0)

endmodule

bind block_cache_tag_lru bctl_checker u_bctl_checker (.*);

>>> test/tb_block_cache_tag_lru.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block cache tag and LRU engine: testbench
// Streams lookups and flushes into the engine, predicts every result with a
// local tag store and stamp model, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_block_cache_tag_lru
   import bctl_pkg::*;
();

   localparam int SLOTS       = 16;
   localparam int BLOCK_BYTES = 512;
   localparam int RANDOM_ITEMS = 530;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int CALM_FIRST   = 250;
   localparam int CALM_LAST    = 349;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      op_type                   op;
      logic [FILE_ID_W-1:0]     file_id;
      logic                     mounted;
      logic [FILE_SIZE_W-1:0]   size;
      logic [BLOCK_NUM_W-1:0]   block;
   } cache_item_type;

   typedef struct {
      status_type               status;
      logic [SLOT_W-1:0]        slot;
      logic [BYTE_COUNT_W-1:0]  bytes;
      logic [TOTAL_W-1:0]       hits;
      logic [TOTAL_W-1:0]       misses;
      logic [TOTAL_W-1:0]       fills;
   } cache_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic                   taken_valid = 1'b0;
   logic [REQ_TDATA_W-1:0] taken_tdata = '0;
   logic                   taken_tuser = 1'b0;

   cache_item_type   pending_items[$];
   cache_result_type results_due[$];

   logic                     tag_valid[SLOTS];
   logic [FILE_ID_W-1:0]     tag_file[SLOTS];
   logic [BLOCK_NUM_W-1:0]   tag_block[SLOTS];
   logic [BYTE_COUNT_W-1:0]  tag_bytes[SLOTS];
   logic [STAMP_W-1:0]       tag_stamp[SLOTS];
   logic [STAMP_W-1:0]       use_clock;
   logic [TOTAL_W-1:0]       hit_count;
   logic [TOTAL_W-1:0]       miss_count;
   logic [TOTAL_W-1:0]       fill_count;

   int items_taken = 0;
   int results_checked = 0;
   int mismatches = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int cycles = 0;

   block_cache_tag_lru #(
      .SLOTS      (SLOTS),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void clear_cache();
      for (int i = 0; i < SLOTS; i++) begin
         tag_valid[i] = 1'b0;
         tag_file[i]  = '0;
         tag_block[i] = '0;
         tag_bytes[i] = '0;
         tag_stamp[i] = '0;
      end
      use_clock  = '0;
      hit_count  = '0;
      miss_count = '0;
      fill_count = '0;
   endfunction

   function automatic cache_result_type cache_step(cache_item_type it);
      cache_result_type r;
      logic [FILE_SIZE_W:0] start;
      logic [FILE_SIZE_W:0] tail;
      logic [STAMP_W-1:0]   oldest;
      int                   victim;
      r.status = STATUS_HIT;
      r.slot   = '0;
      r.bytes  = '0;
      if (it.op == OP_FLUSH) begin
         clear_cache();
      end else begin
         victim = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (victim < 0 && tag_valid[i] && tag_block[i] == it.block
                && tag_file[i] == it.file_id) begin
               victim = i;
            end
         end
         if (victim >= 0) begin
            use_clock = use_clock + 1;
            tag_stamp[victim] = use_clock;
            hit_count = hit_count + 1;
            r.slot  = SLOT_W'(victim);
            r.bytes = tag_bytes[victim];
         end else begin
            miss_count = miss_count + 1;
            start = (FILE_SIZE_W+1)'(it.block) * (FILE_SIZE_W+1)'(BLOCK_BYTES);
            if (!it.mounted) begin
               r.status = STATUS_UNMOUNTED;
            end else if (start >= {1'b0, it.size}) begin
               r.status = STATUS_PAST_END;
            end else begin
               tail = {1'b0, it.size} - start;
               if (tail > (FILE_SIZE_W+1)'(BLOCK_BYTES)) begin
                  tail = (FILE_SIZE_W+1)'(BLOCK_BYTES);
               end
               oldest = STAMP_MAX;
               for (int i = 0; i < SLOTS; i++) begin
                  if (victim < 0 || tag_valid[victim]) begin
                     if (!tag_valid[i]) begin
                        victim = i;
                     end else if (tag_stamp[i] < oldest) begin
                        oldest = tag_stamp[i];
                        victim = i;
                     end
                  end
               end
               if (victim < 0) begin
                  r.status = STATUS_NO_SLOT;
               end else begin
                  tag_valid[victim] = 1'b1;
                  tag_file[victim]  = it.file_id;
                  tag_block[victim] = it.block;
                  tag_bytes[victim] = BYTE_COUNT_W'(tail);
                  use_clock = use_clock + 1;
                  tag_stamp[victim] = use_clock;
                  fill_count = fill_count + 1;
                  r.status = STATUS_FILLED;
                  r.slot   = SLOT_W'(victim);
                  r.bytes  = BYTE_COUNT_W'(tail);
               end
            end
         end
      end
      r.hits   = hit_count;
      r.misses = miss_count;
      r.fills  = fill_count;
      return r;
   endfunction

   function automatic cache_item_type make_item(op_type op, int file_id, bit mounted,
                                                logic [31:0] size, logic [22:0] block);
      cache_item_type it;
      it.op      = op;
      it.file_id = FILE_ID_W'(file_id);
      it.mounted = mounted;
      it.size    = size;
      it.block   = block;
      return it;
   endfunction

   function automatic cache_item_type random_item();
      cache_item_type it;
      int unsigned pick;
      pick = $urandom_range(99);
      it.op      = (pick < 2) ? OP_FLUSH : OP_LOOKUP;
      it.file_id = FILE_ID_W'($urandom());
      it.mounted = 1'($urandom());
      it.size    = $urandom();
      it.block   = BLOCK_NUM_W'($urandom());
      if (pick >= 2 && pick < 82) begin
         if ($urandom_range(3) != 0) begin
            it.file_id = FILE_ID_W'($urandom_range(3));
         end
         it.block   = BLOCK_NUM_W'($urandom_range(11));
         it.mounted = ($urandom_range(19) != 0);
         if ($urandom_range(3) == 0) begin
            it.size = 32'(it.block) * BLOCK_BYTES + $urandom_range(1, 600);
         end else begin
            it.size = it.size | 32'h0100_0000;
         end
      end
      return it;
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         taken_valid <= 1'b0;
      end else begin
         taken_valid <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            taken_tdata <= req_tdata;
            taken_tuser <= req_tuser;
            items_taken <= items_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 && ((items_taken >= CALM_FIRST
                && items_taken <= CALM_LAST) || $urandom_range(99) >= 14)) begin
               cache_item_type it;
               it = pending_items.pop_front();
               req_tdata  <= {5'd0, it.block, it.size, it.mounted, it.file_id};
               req_tuser  <= it.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_checked == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         clear_cache();
      end else begin
         if (taken_valid) begin
            cache_item_type it;
            it.op      = op_type'(taken_tuser);
            it.file_id = taken_tdata[2:0];
            it.mounted = taken_tdata[3];
            it.size    = taken_tdata[35:4];
            it.block   = taken_tdata[58:36];
            results_due.push_back(cache_step(it));
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked <= results_checked + 1;
            if (results_due.size() == 0) begin
               report_mismatch("result item with no request outstanding");
            end else begin
               cache_result_type want;
               want = results_due.pop_front();
               if (rsp_tdata[2:0] !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_tdata[2:0], want.status));
               if (rsp_tdata[6:3] !== want.slot)
                  report_mismatch($sformatf("slot got %0d want %0d",
                                            rsp_tdata[6:3], want.slot));
               if (rsp_tdata[16:7] !== want.bytes)
                  report_mismatch($sformatf("byte_count got %0d want %0d",
                                            rsp_tdata[16:7], want.bytes));
               if (rsp_tdata[48:17] !== want.hits)
                  report_mismatch($sformatf("hit_total got %0d want %0d",
                                            rsp_tdata[48:17], want.hits));
               if (rsp_tdata[80:49] !== want.misses)
                  report_mismatch($sformatf("miss_total got %0d want %0d",
                                            rsp_tdata[80:49], want.misses));
               if (rsp_tdata[112:81] !== want.fills)
                  report_mismatch($sformatf("fill_total got %0d want %0d",
                                            rsp_tdata[112:81], want.fills));
            end
         end
         rsp_tready <= (hold_left == 0) && ((results_checked >= CALM_FIRST
                       && results_checked <= CALM_LAST) || $urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      pending_items.push_back(make_item(OP_FLUSH, 0, 1'b0, 32'd0, 23'd0));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd0, 23'd0));
      pending_items.push_back(make_item(OP_LOOKUP, 7, 1'b0, 32'hFFFF_FFFF, 23'd5));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd1000, 23'd0));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd1000, 23'd1));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd1000, 23'd2));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b0, 32'd0, 23'd0));
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd0, 23'd1));
      pending_items.push_back(make_item(OP_LOOKUP, 7, 1'b1, 32'hFFFF_FFFF, 23'h7F_FFFF));
      pending_items.push_back(make_item(OP_LOOKUP, 3, 1'b1, 32'd512, 23'd1));
      pending_items.push_back(make_item(OP_LOOKUP, 3, 1'b1, 32'd513, 23'd1));
      pending_items.push_back(make_item(OP_LOOKUP, 7, 1'b1, 32'hFFFF_FFFF, 23'h7F_FFFF));
      for (int b = 0; b < 13; b++) begin
         pending_items.push_back(make_item(OP_LOOKUP, 5, 1'b1, 32'hFFFF_FFFF, 23'(b)));
      end
      pending_items.push_back(make_item(OP_LOOKUP, 0, 1'b1, 32'd1000, 23'd0));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_items.push_back(random_item());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_tvalid || taken_valid
             || results_due.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/bctl_pkg.sv
hdl/bctl_ram.sv
hdl/block_cache_tag_lru.sv
hdl/bctl_checker.sv
test/tb_block_cache_tag_lru.sv
